/* design/swst_pkg.sv */
// Shared types and constants for the sliding window statistics block.
// Used by the cells, the divider, the square root unit and the top level.
package swst_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;
   localparam int SAMPLE_W    = 24;
   localparam int SUM_W       = 30;
   localparam int SQSUM_W     = 53;
   localparam int VAR_W       = 47;
   localparam int DIV_NUM_W   = 60;
   localparam int DIV_DEN_W   = 14;
   localparam int SQRT_IN_W   = 48;
   localparam int SQRT_OUT_W  = 24;
   localparam int RSP_W       = 160;
   localparam int LEN_RESET   = 10;

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_REMOVE = 2'd1,
      CELL_INSERT = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type                op;
      logic signed [SAMPLE_W-1:0] key;
   } cell_ctl_type;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_REMOVE = 11'b00000000010,
      S_INSERT = 11'b00000000100,
      S_MED0   = 11'b00000001000,
      S_MED1   = 11'b00000010000,
      S_MUL    = 11'b00000100000,
      S_DIVM   = 11'b00001000000,
      S_DIVV   = 11'b00010000000,
      S_SQRT   = 11'b00100000000,
      S_DONE   = 11'b01000000000,
      S_CLEAR  = 11'b10000000000
   } state_type;

endpackage

/* design/swst_cell.sv */
// One cell of the sorted window row: holds one value, shifts with its neighbors.
// Depends on swst_pkg.
module swst_cell (
   input  logic                                clock,
   input  swst_pkg::cell_ctl_type              ctl,
   input  logic                                left_live,
   input  logic signed [swst_pkg::SAMPLE_W-1:0] left_val,
   input  logic signed [swst_pkg::SAMPLE_W-1:0] right_val,
   input  logic                                own_live,
   input  logic                                reach,
   output logic signed [swst_pkg::SAMPLE_W-1:0] value
);
   import swst_pkg::*;

   logic signed [SAMPLE_W-1:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         CELL_REMOVE: begin
            if (own_live && value_ff >= ctl.key) value_in = right_val;
         end
         CELL_INSERT: begin
            if (reach) begin
               if (left_live && left_val > ctl.key) value_in = left_val;
               else if (!own_live || value_ff > ctl.key) value_in = ctl.key;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

/* design/swst_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on swst_pkg.
module swst_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [swst_pkg::DIV_NUM_W-1:0]     num,
   input  logic [swst_pkg::DIV_DEN_W-1:0]     den,
   output logic                               done,
   output logic [swst_pkg::DIV_NUM_W-1:0]     quot
);
   import swst_pkg::*;

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial, diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign ge    = trial >= {1'b0, den};
   assign diff  = trial - {1'b0, den};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

/* design/swst_sqrt.sv */
// Digit by digit floor square root, one result bit per cycle.
// Depends on swst_pkg.
module swst_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [swst_pkg::SQRT_IN_W-1:0]     radicand,
   output logic                               done,
   output logic [swst_pkg::SQRT_OUT_W-1:0]    root
);
   import swst_pkg::*;

   logic                    busy_ff, busy_in, done_ff, done_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [SQRT_OUT_W+1:0]   rem_ff, rem_in;
   logic [SQRT_OUT_W-1:0]   root_ff, root_in;
   logic [SQRT_IN_W-1:0]    x_ff, x_in;
   logic [SQRT_OUT_W+3:0]   cur, diff;
   logic [SQRT_OUT_W+1:0]   trial;
   logic                    ge;

   assign cur   = {rem_ff, x_ff[SQRT_IN_W-1:SQRT_IN_W-2]};
   assign trial = {root_ff, 2'b01};
   assign ge    = cur >= {2'b00, trial};
   assign diff  = cur - {2'b00, trial};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      x_in    = x_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         root_in = '0;
         x_in    = radicand;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[SQRT_OUT_W+1:0] : cur[SQRT_OUT_W+1:0];
         root_in = {root_ff[SQRT_OUT_W-2:0], ge};
         x_in    = {x_ff[SQRT_IN_W-3:0], 2'b00};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(SQRT_OUT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      x_ff    <= x_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

/* design/sliding_window_statistics.sv */
// Sliding window statistics: sample ring, sorted cell row, divider and square root.
// Depends on swst_pkg, swst_cell, swst_divider, swst_sqrt.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser action, tdata sample
//   rsp      out  rsp_tvalid/rsp_tready  tdata count,sum,mean,median,variance,stddev
//   csr      in   csr_valid/csr_ready    csr_wdata window_length
//
// An add item goes from accept through the window update and median, the two divisions
// (mean, then variance), the square root unit, the load of the output register and the
// return to idle; a clear item zeroes the window and then loads the output register.
// One item is worked at a time; req_tready is high only between items.
// A finished result waits in the output register while the next item runs.
// Synchronous reset empties the window and sets window_length to 10.
module sliding_window_statistics (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // [23:0] sample
   input  logic         req_tuser,   // [0] action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // [6:0] sample_count, [36:7] window_sum,
                                     // [60:37] window_mean, [84:61] window_median,
                                     // [131:85] window_variance, [155:132] std_deviation
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_wdata    // [6:0] window_length
);
   import swst_pkg::*;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           win_len_ff, win_len_in, len_eff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           oldest_ff, oldest_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQSUM_W-1:0]         sqsum_ff, sqsum_in;
   logic signed [SAMPLE_W-1:0] samp_ff, samp_in;
   logic                       drop_ff, drop_in;
   logic signed [SAMPLE_W-1:0] ring_rd_ff;
   logic signed [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] hi_ff, hi_in, median_ff, median_in, mean_ff, mean_in;
   logic [DIV_NUM_W-1:0]       prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [VAR_W-1:0]           var_ff, var_in;
   logic [SQRT_OUT_W-1:0]      sd_ff, sd_in;
   logic                       div_start_ff, div_start_in, sqrt_start_ff, sqrt_start_in;
   logic [DIV_NUM_W-1:0]       div_num_ff, div_num_in;
   logic [DIV_DEN_W-1:0]       div_den_ff, div_den_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;

   logic                       div_done, sqrt_done;
   logic [DIV_NUM_W-1:0]       div_quot;
   logic [SQRT_OUT_W-1:0]      sqrt_root;
   logic signed [2*SAMPLE_W-1:0] old_sq_s, new_sq_s;
   logic signed [2*SUM_W-1:0]  sum_sq_s;
   logic [DIV_NUM_W-1:0]       n_sqsum;
   logic [SUM_W-1:0]           sum_mag;
   logic signed [SAMPLE_W:0]   med_pair;
   logic [IDX_W-1:0]           ring_waddr, mid_idx;
   logic                       ring_we;
   cell_ctl_type               cell_ctl;
   logic signed [SAMPLE_W-1:0] cell_val [MAX_WINDOW];

   assign len_eff = (win_len_ff == '0) ? CNT_W'(1) :
                    (win_len_ff > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : win_len_ff;
   assign old_sq_s   = ring_rd_ff * ring_rd_ff;
   assign new_sq_s   = samp_ff * samp_ff;
   assign sum_sq_s   = sum_ff * sum_ff;
   assign n_sqsum    = DIV_NUM_W'(count_ff) * DIV_NUM_W'(sqsum_ff);
   assign sum_mag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mid_idx    = count_ff[CNT_W-1:1];
   assign med_pair   = (SAMPLE_W+1)'(cell_val[mid_idx - IDX_W'(1)]) + (SAMPLE_W+1)'(hi_ff);
   assign ring_waddr = oldest_ff + count_ff[IDX_W-1:0];
   assign ring_we    = (state_ff == S_INSERT);

   assign cell_ctl.op  = (state_ff == S_REMOVE && drop_ff) ? CELL_REMOVE :
                         (state_ff == S_INSERT) ? CELL_INSERT : CELL_HOLD;
   assign cell_ctl.key = (state_ff == S_REMOVE) ? ring_rd_ff : samp_ff;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic signed [SAMPLE_W-1:0] left_v, right_v;
      logic                       left_l;
      if (i == 0) begin : g_first
         assign left_v = '0;
         assign left_l = 1'b0;
      end else begin : g_mid
         assign left_v = cell_val[i-1];
         assign left_l = (CNT_W'(i - 1) < count_ff);
      end
      if (i == MAX_WINDOW - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_body
         assign right_v = cell_val[i+1];
      end
      swst_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .left_live (left_l),
         .left_val  (left_v),
         .right_val (right_v),
         .own_live  (CNT_W'(i) < count_ff),
         .reach     (CNT_W'(i) <= count_ff),
         .value     (cell_val[i])
      );
   end

   swst_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   swst_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand ({1'b0, var_ff}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_waddr] <= samp_ff;
      ring_rd_ff <= ring_mem[oldest_ff];
   end

   always_comb begin
      state_in      = state_ff;
      win_len_in    = win_len_ff;
      count_in      = count_ff;
      oldest_in     = oldest_ff;
      sum_in        = sum_ff;
      sqsum_in      = sqsum_ff;
      samp_in       = samp_ff;
      drop_in       = drop_ff;
      hi_in         = hi_ff;
      median_in     = median_ff;
      mean_in       = mean_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      var_in        = var_ff;
      sd_in         = sd_ff;
      div_start_in  = 1'b0;
      sqrt_start_in = 1'b0;
      div_num_in    = div_num_ff;
      div_den_in    = div_den_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid) win_len_in = csr_wdata;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               samp_in = req_tdata;
               drop_in = (count_ff >= len_eff);
               if (req_tuser == ACT_CLEAR) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_REMOVE;
               end
            end
         end
         S_CLEAR: begin
            count_in  = '0;
            oldest_in = '0;
            sum_in    = '0;
            sqsum_in  = '0;
            mean_in   = '0;
            median_in = '0;
            var_in    = '0;
            sd_in     = '0;
            state_in  = S_DONE;
         end
         S_REMOVE: begin
            if (drop_ff) begin
               sum_in    = sum_ff - SUM_W'(ring_rd_ff);
               sqsum_in  = sqsum_ff - SQSUM_W'($unsigned(old_sq_s));
               oldest_in = oldest_ff + IDX_W'(1);
               count_in  = count_ff - CNT_W'(1);
            end
            state_in = S_INSERT;
         end
         S_INSERT: begin
            sum_in   = sum_ff + SUM_W'(samp_ff);
            sqsum_in = sqsum_ff + SQSUM_W'($unsigned(new_sq_s));
            count_in = count_ff + CNT_W'(1);
            state_in = S_MED0;
         end
         S_MED0: begin
            hi_in    = cell_val[mid_idx];
            state_in = S_MED1;
         end
         S_MED1: begin
            median_in = count_ff[0] ? hi_ff : med_pair[SAMPLE_W:1];
            state_in  = S_MUL;
         end
         S_MUL: begin
            prod_a_in    = n_sqsum;
            prod_b_in    = DIV_NUM_W'($unsigned(sum_sq_s));
            div_num_in   = DIV_NUM_W'(sum_mag);
            div_den_in   = DIV_DEN_W'(count_ff);
            div_start_in = 1'b1;
            state_in     = S_DIVM;
         end
         S_DIVM: begin
            if (div_done) begin
               mean_in      = sum_ff[SUM_W-1] ? -SAMPLE_W'(div_quot) : SAMPLE_W'(div_quot);
               div_num_in   = prod_a_ff - prod_b_ff;
               div_den_in   = DIV_DEN_W'(count_ff) * DIV_DEN_W'(count_ff);
               div_start_in = 1'b1;
               state_in     = S_DIVV;
            end
         end
         S_DIVV: begin
            if (div_done) begin
               var_in        = div_quot[VAR_W-1:0];
               sqrt_start_in = 1'b1;
               state_in      = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               sd_in    = sqrt_root;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, sd_ff, var_ff, median_ff, mean_ff, sum_ff, count_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         win_len_ff    <= CNT_W'(LEN_RESET);
         count_ff      <= '0;
         oldest_ff     <= '0;
         sum_ff        <= '0;
         sqsum_ff      <= '0;
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         win_len_ff    <= win_len_in;
         count_ff      <= count_in;
         oldest_ff     <= oldest_in;
         sum_ff        <= sum_in;
         sqsum_ff      <= sqsum_in;
         div_start_ff  <= div_start_in;
         sqrt_start_ff <= sqrt_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      samp_ff     <= samp_in;
      drop_ff     <= drop_in;
      hi_ff       <= hi_in;
      median_ff   <= median_in;
      mean_ff     <= mean_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      var_ff      <= var_in;
      sd_ff       <= sd_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;
endmodule

/* design/swst_checker.sv */
// Port level checks for the sliding window statistics block, bound to the top level.
// Depends on sliding_window_statistics ports only.
module swst_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [23:0]  req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [159:0] rsp_tdata,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [6:0]   csr_wdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] <= 7'd64)
      else $error("sample_count above window size");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6:0] == 7'd0 |-> rsp_tdata[159:7] == '0)
      else $error("empty window with nonzero statistics");

   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");
endmodule

bind sliding_window_statistics swst_checker u_swst_checker (.*);
